### rtl/assert_macros.svh
// assertion macros used by the top level rtl file of the frame downscaler
// no dependencies; expects clk and rst_n in the scope of the caller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// check on every rising edge outside reset
`define FDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check on every rising edge, reset included
`define FDS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FDS_ASSERT(lbl, prop, msg)
`define FDS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/fds_pkg.sv
// shared types, constants and color helpers of the frame downscaler
// no dependencies
`timescale 1ns / 1ps

package fds_pkg;

    // source frame geometry and screen limits
    localparam int SRC_WIDTH      = 256;
    localparam int SRC_HEIGHT     = 240;
    localparam int MAX_LCD_WIDTH  = 320;
    localparam int LCD_HEIGHT_MAX = 240;
    localparam int BANK_SIZE      = SRC_WIDTH * SRC_HEIGHT;

    // frame memory: two banks split by column parity, 256 rows x 128 pairs
    localparam int FRAME_DEPTH = 65536;
    localparam int FRAME_AW    = 16;
    localparam int PAL_DEPTH   = 256;
    localparam int OUT_W       = 33;

    // configuration reset values
    localparam logic [8:0] LCD_WIDTH_RST  = 9'd220;
    localparam logic [7:0] LCD_HEIGHT_RST = 8'd176;

    // configuration register indexes
    localparam logic CFG_LCD_WIDTH  = 1'b0;
    localparam logic CFG_LCD_HEIGHT = 1'b1;

    // request kinds
    typedef enum logic [1:0] {
        REQ_PAL    = 2'd0,
        REQ_FRAME  = 2'd1,
        REQ_SWAP   = 2'd2,
        REQ_RENDER = 2'd3
    } req_t;

    // item fields that travel alongside the divider stages
    typedef struct packed {
        req_t        req;
        logic [5:0]  pal_idx;
        logic [15:0] color;
        logic [15:0] faddr;
        logic [7:0]  pix;
        logic        hit;
        logic        nx_ok;
        logic        ny_ok;
        logic [16:0] saddr;
    } carry_t;

    // per channel average of two rgb565 words, halves summed
    function automatic logic [15:0] blend565(input logic [15:0] a, input logic [15:0] b);
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] bl;
        r  = {1'b0, a[15:12]} + {1'b0, b[15:12]};
        g  = {1'b0, a[10:6]} + {1'b0, b[10:6]};
        bl = {1'b0, a[4:1]} + {1'b0, b[4:1]};
        return {r, g, bl};
    endfunction

endpackage

### rtl/fds_ram.sv
// generic ram: one write port, two registered read ports
// no dependencies
`timescale 1ns / 1ps

module fds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered reads, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

### rtl/fds_div.sv
// two stage restoring divider, four quotient bits per stage
// no dependencies
`timescale 1ns / 1ps

module fds_div (
    input  logic       clk,
    input  logic       en,
    input  logic [8:0] rem_in,
    input  logic [7:0] low_in,
    input  logic [8:0] divisor,
    output logic [7:0] quot,
    output logic [8:0] rem
);

    logic [8:0] rem_a_reg;
    logic [3:0] qh_a_reg;
    logic [3:0] low_a_reg;
    logic [8:0] div_a_reg;
    logic [7:0] quot_reg;
    logic [8:0] rem_reg;

    logic [8:0] rem_a_next;
    logic [3:0] qh_a_next;
    logic [8:0] rem_b_next;
    logic [3:0] ql_b_next;
    logic [9:0] ta;
    logic [9:0] tb;

    // first four steps
    always_comb
    begin
        rem_a_next = rem_in;
        qh_a_next  = 4'd0;
        ta         = 10'd0;
        for (int i = 0; i < 4; i++)
        begin
            ta = {rem_a_next, low_in[7-i]};
            if (ta >= {1'b0, divisor})
            begin
                ta = ta - {1'b0, divisor};
                qh_a_next[3-i] = 1'b1;
            end
            rem_a_next = ta[8:0];
        end
    end

    // last four steps
    always_comb
    begin
        rem_b_next = rem_a_reg;
        ql_b_next  = 4'd0;
        tb         = 10'd0;
        for (int i = 0; i < 4; i++)
        begin
            tb = {rem_b_next, low_a_reg[3-i]};
            if (tb >= {1'b0, div_a_reg})
            begin
                tb = tb - {1'b0, div_a_reg};
                ql_b_next[3-i] = 1'b1;
            end
            rem_b_next = tb[8:0];
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_a_reg <= rem_a_next;
            qh_a_reg  <= qh_a_next;
            low_a_reg <= low_in[3:0];
            div_a_reg <= divisor;
            quot_reg  <= {qh_a_reg, ql_b_next};
            rem_reg   <= rem_b_next;
        end
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

### rtl/fds_out_skid.sv
// output register with skid stage for the result stream
// depends on fds_pkg for the result width
`timescale 1ns / 1ps

module fds_out_skid (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [fds_pkg::OUT_W-1:0] push_data,
    output logic                     en,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [fds_pkg::OUT_W-1:0] out_data
);

    import fds_pkg::*;

    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] skid_data_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign en        = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/frame_downscaler_rgb565_blend.sv
// top level of the frame downscaler: input stage, divider, frame and palette memories
// depends on fds_pkg, fds_ram, fds_div, fds_out_skid and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes one item per clock while the output skid stage is empty and no clear
// pass runs, and returns a rendered pixel for each on-screen render item. Each
// render item maps its screen pixel onto the source frame through a two stage
// divider, reads three source bytes from the display bank together (the bank
// is split into even and odd column memories, each with two read ports), looks
// them up in two copies of the palette and blends them. Palette writes, frame
// writes and bank swaps flow down the same pipeline and take effect in item
// order. After reset the frame memory is cleared one entry per clock; no item
// is accepted during that pass, configuration writes are.
module frame_downscaler_rgb565_blend (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pal_index, red, green, blue, frame_addr, pix_value, out_x, out_y, pad
    input  logic [71:0] s_axis_tdata,
    // req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_color, screen_addr, pad
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    import fds_pkg::*;

    // configuration and control
    logic [8:0]  lcd_width_reg;
    logic [7:0]  lcd_height_reg;
    logic        clr_busy_reg;
    logic [15:0] clr_addr_reg;
    logic        bank_sel_reg;
    logic        en;

    // input stage
    logic        v0_reg;
    req_t        req0_reg;
    logic [71:0] d0_reg;

    // later stages
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    carry_t      c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    logic [7:0]  sx3_reg, sy3_reg;
    logic        fx3_reg, fy3_reg, fx4_reg, fy4_reg, fx5_reg, fy5_reg;
    logic        par4_reg;

    logic [8:0]  w_eff;
    logic [8:0]  h_eff;
    logic [8:0]  x0;
    logic [7:0]  y0;
    logic [15:0] yn0;
    carry_t      c0_next;
    logic [7:0]  qx, qy;
    logic [8:0]  rx, ry;
    logic        fx_next, fy_next;

    logic [7:0]          sx1, sy1;
    logic [FRAME_AW-1:0] a_same, a_right, a_below;
    logic [FRAME_AW-1:0] ev_raddr0, od_raddr0;
    logic                ev_we, od_we;
    logic [FRAME_AW-1:0] f_waddr;
    logic [7:0]          f_wdata;
    logic                item_fwrite;
    logic [7:0]          ev_rd0, ev_rd1, od_rd0, od_rd1;
    logic [7:0]          f0, f1, f2;
    logic                pal_we;
    logic [15:0]         pa0, pa1, pb0, pb1;
    logic [15:0]         col_x, col_y;
    logic                push;

    // effective screen size
    always_comb
    begin
        w_eff = lcd_width_reg;
        if (lcd_width_reg == 9'd0)
        begin
            w_eff = 9'd1;
        end
        else if (lcd_width_reg > 9'(MAX_LCD_WIDTH))
        begin
            w_eff = 9'(MAX_LCD_WIDTH);
        end
        h_eff = {1'b0, lcd_height_reg};
        if (lcd_height_reg == 8'd0)
        begin
            h_eff = 9'd1;
        end
        else if (lcd_height_reg > 8'(LCD_HEIGHT_MAX))
        begin
            h_eff = 9'(LCD_HEIGHT_MAX);
        end
    end

    // configuration writes, frame clearing pass and bank select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcd_width_reg  <= LCD_WIDTH_RST;
            lcd_height_reg <= LCD_HEIGHT_RST;
            clr_busy_reg   <= 1'b1;
            clr_addr_reg   <= 16'd0;
            bank_sel_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LCD_WIDTH:  lcd_width_reg  <= cfg_data;
                    CFG_LCD_HEIGHT: lcd_height_reg <= cfg_data[7:0];
                    default:        lcd_width_reg  <= lcd_width_reg;
                endcase
            end
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 16'd1;
                if (clr_addr_reg == 16'hFFFF)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (en && v3_reg && c3_reg.req == REQ_SWAP)
            begin
                bank_sel_reg <= !bank_sel_reg;
            end
        end
    end

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = en && !clr_busy_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_axis_tvalid && s_axis_tready;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // item decode at the input stage
    assign x0  = d0_reg[62:54];
    assign y0  = d0_reg[70:63];
    assign yn0 = {y0, 8'h00} - {4'h0, y0, 4'h0};

    always_comb
    begin
        c0_next.req     = req0_reg;
        c0_next.pal_idx = d0_reg[5:0];
        c0_next.color   = {d0_reg[13:9], d0_reg[21:16], d0_reg[29:25]};
        c0_next.faddr   = d0_reg[45:30];
        c0_next.pix     = d0_reg[53:46];
        c0_next.hit     = (req0_reg == REQ_RENDER) && (x0 < w_eff) && ({1'b0, y0} < h_eff);
        c0_next.nx_ok   = ({1'b0, x0} + 10'd1) < {1'b0, w_eff};
        c0_next.ny_ok   = ({1'b0, y0} + 9'd1) < h_eff;
        c0_next.saddr   = ({9'd0, y0} * {8'd0, w_eff}) + {8'd0, x0};
    end

    // source column and row dividers
    fds_div u_div_x (
        .clk     (clk),
        .en      (en),
        .rem_in  (x0),
        .low_in  (8'd0),
        .divisor (w_eff),
        .quot    (qx),
        .rem     (rx)
    );

    fds_div u_div_y (
        .clk     (clk),
        .en      (en),
        .rem_in  ({1'b0, yn0[15:8]}),
        .low_in  (yn0[7:0]),
        .divisor (h_eff),
        .quot    (qy),
        .rem     (ry)
    );

    // neighbour blend decisions from the remainders, on-screen renders only
    assign fx_next = c2_reg.hit && c2_reg.nx_ok &&
                     (({1'b0, rx} + 10'd256) >= {1'b0, w_eff});
    assign fy_next = c2_reg.hit && c2_reg.ny_ok &&
                     (({1'b0, ry} + 10'd240) >= {1'b0, h_eff});

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            req0_reg <= req_t'(s_axis_tuser);
            d0_reg   <= s_axis_tdata;
            c1_reg   <= c0_next;
            c2_reg   <= c1_reg;
            c3_reg   <= c2_reg;
            sx3_reg  <= qx;
            sy3_reg  <= qy;
            fx3_reg  <= fx_next;
            fy3_reg  <= fy_next;
            c4_reg   <= c3_reg;
            fx4_reg  <= fx3_reg;
            fy4_reg  <= fy3_reg;
            par4_reg <= sx3_reg[0];
            c5_reg   <= c4_reg;
            fx5_reg  <= fx4_reg;
            fy5_reg  <= fy4_reg;
        end
    end

    // frame memory addresses: pixel, right neighbour, pixel below
    assign sx1     = sx3_reg + 8'd1;
    assign sy1     = sy3_reg + 8'd1;
    assign a_same  = {bank_sel_reg, sy3_reg, sx3_reg[7:1]};
    assign a_right = {bank_sel_reg, sy3_reg, sx1[7:1]};
    assign a_below = {bank_sel_reg, sy1, sx3_reg[7:1]};
    assign ev_raddr0 = sx3_reg[0] ? a_right : a_same;
    assign od_raddr0 = sx3_reg[0] ? a_same : a_right;

    // frame write port, shared with the clearing pass
    assign item_fwrite = en && v3_reg && (c3_reg.req == REQ_FRAME) &&
                         ({1'b0, c3_reg.faddr} < 17'(BANK_SIZE));
    assign ev_we   = clr_busy_reg || (item_fwrite && !c3_reg.faddr[0]);
    assign od_we   = clr_busy_reg || (item_fwrite && c3_reg.faddr[0]);
    assign f_waddr = clr_busy_reg ? clr_addr_reg
                                  : {!bank_sel_reg, c3_reg.faddr[15:8], c3_reg.faddr[7:1]};
    assign f_wdata = clr_busy_reg ? 8'd0 : c3_reg.pix;

    fds_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_frame_even (
        .clk    (clk),
        .we     (ev_we),
        .waddr  (f_waddr),
        .wdata  (f_wdata),
        .re     (en),
        .raddr0 (ev_raddr0),
        .raddr1 (a_below),
        .rdata0 (ev_rd0),
        .rdata1 (ev_rd1)
    );

    fds_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_frame_odd (
        .clk    (clk),
        .we     (od_we),
        .waddr  (f_waddr),
        .wdata  (f_wdata),
        .re     (en),
        .raddr0 (od_raddr0),
        .raddr1 (a_below),
        .rdata0 (od_rd0),
        .rdata1 (od_rd1)
    );

    // route frame bytes by column parity
    assign f0 = par4_reg ? od_rd0 : ev_rd0;
    assign f1 = par4_reg ? ev_rd0 : od_rd0;
    assign f2 = par4_reg ? od_rd1 : ev_rd1;

    // palette copies, written together
    assign pal_we = en && v4_reg && (c4_reg.req == REQ_PAL);

    fds_ram #(.WIDTH(16), .DEPTH(PAL_DEPTH)) u_pal_a (
        .clk    (clk),
        .we     (pal_we),
        .waddr  ({2'b01, c4_reg.pal_idx}),
        .wdata  (c4_reg.color),
        .re     (en),
        .raddr0 (f0),
        .raddr1 (f1),
        .rdata0 (pa0),
        .rdata1 (pa1)
    );

    fds_ram #(.WIDTH(16), .DEPTH(PAL_DEPTH)) u_pal_b (
        .clk    (clk),
        .we     (pal_we),
        .waddr  ({2'b01, c4_reg.pal_idx}),
        .wdata  (c4_reg.color),
        .re     (en),
        .raddr0 (f2),
        .raddr1 (f2),
        .rdata0 (pb0),
        .rdata1 (pb1)
    );

    // blend right, then below
    assign col_x = fx5_reg ? blend565(pa0, pa1) : pa0;
    assign col_y = fy5_reg ? blend565(col_x, pb0) : col_x;
    assign push  = en && v5_reg && c5_reg.hit;

    logic [OUT_W-1:0] out_data;

    fds_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({c5_reg.saddr, col_y}),
        .en        (en),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = {7'd0, out_data};

    // second palette copy port carries the same address
    `FDS_ASSERT(a_pal_copy, (!(v5_reg && fy5_reg)) || (pb1 == pb0), "palette copy mismatch")
    `FDS_ASSERT(a_no_item_clear, !(clr_busy_reg && s_axis_tready), "item taken during clear")
    `FDS_ASSERT(a_stall_hold, !en |=> $stable(v5_reg) && $stable(c5_reg), "stage moved in stall")
    `FDS_ASSERT(a_blend_render, (v3_reg && (fx3_reg || fy3_reg)) |-> c3_reg.req == REQ_RENDER,
        "blend flag on non-render item")
    `FDS_ASSERT_ALWAYS(a_out_skid, !(en == 1'b0 && m_axis_tvalid == 1'b0), "skid without output")

endmodule
